[src/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on a rising edge with an asynchronous reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that also checks during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[src/mfde_pkg.sv]
// Shared types and constants of the frame store drawing engine.
// No dependencies.
`timescale 1ns / 1ps
package mfde_pkg;
  localparam int unsigned ScreenColumns = 128;
  localparam int unsigned ScreenPages = 8;
  localparam int unsigned ColW = $clog2(ScreenColumns);
  localparam int unsigned PageW = (ScreenPages > 1) ? $clog2(ScreenPages) : 1;
  localparam int unsigned StoreBytes = ScreenColumns * ScreenPages;
  localparam int unsigned AddrW = $clog2(StoreBytes);
  localparam int unsigned ScreenRows = ScreenPages * 8;
  localparam int unsigned CoordW = 10;

  localparam logic [2:0] ModeSet = 3'd0;
  localparam logic [2:0] ModeGet = 3'd1;
  localparam logic [2:0] ModeLine = 3'd2;
  localparam logic [2:0] ModeRect = 3'd3;
  localparam logic [2:0] ModeCircle = 3'd4;
  localparam logic [2:0] ModeFill = 3'd5;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] x_start;
    logic [5:0] y_start;
    logic [6:0] x_end;
    logic [5:0] y_end;
    logic [6:0] radius;
    logic [7:0] rect_width;
    logic [6:0] rect_height;
    logic color;
    logic [7:0] fill_byte;
  } cmd_t;
endpackage

[src/mfde_front.sv]
// Command front end: registers accepted words into a two-entry queue.
// Depends on mfde_pkg.
`timescale 1ns / 1ps
module mfde_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  mfde_pkg::cmd_t   cmd_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output mfde_pkg::cmd_t   cmd_o
);
  import mfde_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign stall_o = (cnt_q == 2'd2);
  assign push = valid_i && !stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end
endmodule

[src/mfde_back.sv]
// Command back end: rasterizes points and performs read-modify-write on the store.
// Depends on mfde_pkg.
`timescale 1ns / 1ps
module mfde_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  input  mfde_pkg::cmd_t   cmd_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic             pixel_value_o
);
  import mfde_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StClear = 4'd1;
  localparam logic [3:0] StLineSetup = 4'd2;
  localparam logic [3:0] StLine = 4'd3;
  localparam logic [3:0] StCircle = 4'd4;
  localparam logic [3:0] StFill = 4'd5;
  localparam logic [3:0] StGet = 4'd6;
  localparam logic [3:0] StRectNext = 4'd7;
  localparam logic [3:0] StDrain = 4'd8;
  localparam logic [3:0] StResult = 4'd9;
  localparam logic [3:0] StCircPlot = 4'd10;

  logic [7:0] mem [StoreBytes];

  logic [3:0] state_q, state_d;
  logic [AddrW-1:0] sweep_q;
  cmd_t cmd_q;
  logic pix_q;

  // Point issue stage.
  logic   pt_v;
  coord_t pt_x, pt_y;
  // Read stage.
  logic   rd_v_q;
  logic [AddrW-1:0] rd_a_q;
  logic [2:0] rd_b_q;
  logic [7:0] rd_data_q;
  // Write stage.
  logic   wr_v_q;
  logic [AddrW-1:0] wr_a_q;
  logic [7:0] fwd_data;
  logic [7:0] wr_data_q;
  logic   fill_we;
  // Byte written in the previous cycle, not yet visible to the read port.
  logic   hold_v_q;
  logic [AddrW-1:0] hold_a_q;
  logic [7:0] hold_data_q;

  // Line walker.
  coord_t lx1_q, ly1_q, lx2_q, ly2_q;
  coord_t x_q, y_q, xe_q, d_q, inc1_q, inc2_q;
  logic   steep_q, tx_q, ty_q;
  logic   first_q;
  logic [1:0] edge_q;

  // Circle walker.
  coord_t px_q, py_q, cd_q;
  logic [2:0] oct_q;

  coord_t ldx, ldy;
  logic   lsteep;

  always_comb begin
    ldx = (lx2_q >= lx1_q) ? lx2_q - lx1_q : lx1_q - lx2_q;
    ldy = (ly2_q >= ly1_q) ? ly2_q - ly1_q : ly1_q - ly2_q;
    lsteep = ldx < ldy;
  end

  function automatic logic on_scr(coord_t x, coord_t y);
    return x >= 0 && y >= 0 && x < coord_t'(ScreenColumns) && y < coord_t'(ScreenRows);
  endfunction

  // Point selection per state.
  coord_t cx, cy;
  always_comb begin
    pt_v = 1'b0;
    pt_x = '0;
    pt_y = '0;
    cx = coord_t'(cmd_q.x_start);
    cy = coord_t'(cmd_q.y_start);
    unique case (state_q)
      StLineSetup: begin
        pt_v = 1'b1;
        pt_x = lx1_q;
        pt_y = ly1_q;
      end
      StLine: begin
        pt_v = 1'b1;
        pt_x = steep_q ? y_q : x_q;
        pt_y = steep_q ? x_q : y_q;
      end
      StGet: begin
        pt_x = cx;
        pt_y = cy;
      end
      StCircPlot: begin
        pt_v = 1'b1;
        case (oct_q)
          3'd0: begin pt_x = cx + px_q; pt_y = cy + py_q; end
          3'd1: begin pt_x = cx + px_q; pt_y = cy - py_q; end
          3'd2: begin pt_x = cx - px_q; pt_y = cy + py_q; end
          3'd3: begin pt_x = cx - px_q; pt_y = cy - py_q; end
          3'd4: begin pt_x = cx + py_q; pt_y = cy + px_q; end
          3'd5: begin pt_x = cx + py_q; pt_y = cy - px_q; end
          3'd6: begin pt_x = cx - py_q; pt_y = cy + px_q; end
          default: begin pt_x = cx - py_q; pt_y = cy - px_q; end
        endcase
      end
      default: ;
    endcase
  end

  // Line step in the walker's own coordinates.
  logic   step_y;
  coord_t y_step, d_step;
  always_comb begin
    step_y = !d_q[CoordW-1];
    y_step = step_y ? (ty_q ? y_q + coord_t'(1) : y_q - coord_t'(1)) : y_q;
    d_step = step_y ? d_q + inc2_q : d_q + inc1_q;
  end

  // The end column itself is never plotted by the walk.
  coord_t x_next;
  logic   line_last;
  assign x_next = tx_q ? x_q + coord_t'(1) : x_q - coord_t'(1);
  assign line_last = (x_next == xe_q);

  logic [AddrW-1:0] pt_addr;
  assign pt_addr = AddrW'(pt_y[PageW+2:3]) * AddrW'(ScreenColumns)
                 + AddrW'(pt_x[ColW-1:0]);

  // Forward the bytes still in flight so close hits on one byte see them.
  always_comb begin
    if (wr_v_q && wr_a_q == rd_a_q) begin
      fwd_data = wr_data_q;
    end else if (hold_v_q && hold_a_q == rd_a_q) begin
      fwd_data = hold_data_q;
    end else begin
      fwd_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_v_q) begin
      mem[wr_a_q] <= wr_data_q;
    end else if (fill_we) begin
      mem[sweep_q] <= (state_q == StClear) ? 8'h00 : cmd_q.fill_byte;
    end
    rd_data_q <= mem[pt_addr];
  end

  logic [7:0] mod_data;
  always_comb begin
    mod_data = fwd_data;
    mod_data[rd_b_q] = cmd_q.color;
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= pt_addr;
    rd_b_q <= pt_y[2:0];
    wr_a_q <= rd_a_q;
    wr_data_q <= mod_data;
    hold_a_q <= wr_a_q;
    hold_data_q <= wr_data_q;
  end

  assign fill_we = (state_q == StClear) || (state_q == StFill);
  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i;
  assign valid_o = (state_q == StResult);
  assign pixel_value_o = pix_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.mode) inside
            ModeSet, ModeLine: state_d = StLineSetup;
            ModeGet: state_d = StGet;
            ModeRect: begin
              state_d = (cmd_i.rect_width == 8'd0 || cmd_i.rect_height == 7'd0)
                      ? StResult : StRectNext;
            end
            ModeCircle: state_d = StCircPlot;
            ModeFill: state_d = StFill;
            default: state_d = StResult;
          endcase
        end
      end
      StClear: if (sweep_q == AddrW'(StoreBytes - 1)) state_d = StIdle;
      StFill: if (sweep_q == AddrW'(StoreBytes - 1)) state_d = StDrain;
      StRectNext: state_d = StLineSetup;
      StLineSetup: begin
        if (cmd_q.mode == ModeSet || (lx1_q == lx2_q && ly1_q == ly2_q)) begin
          state_d = (cmd_q.mode == ModeRect && edge_q != 2'd3) ? StRectNext : StDrain;
        end else begin
          state_d = StLine;
        end
      end
      StLine: begin
        if (first_q) begin
          state_d = StLine;
        end else if (line_last) begin
          state_d = (cmd_q.mode == ModeRect && edge_q != 2'd3) ? StRectNext : StDrain;
        end
      end
      StCircPlot: begin
        if (oct_q == 3'd7 &&
            !(px_q + coord_t'(1) <= ((!cd_q[CoordW-1]) ? py_q - coord_t'(1) : py_q))) begin
          state_d = StDrain;
        end
      end
      StGet: state_d = StDrain;
      StDrain: state_d = StResult;
      StResult: if (!stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  coord_t rx, ry, rxr, ryb;
  always_comb begin
    rx = coord_t'(cmd_q.x_start);
    ry = coord_t'(cmd_q.y_start);
    rxr = rx + coord_t'(cmd_q.rect_width) - coord_t'(1);
    ryb = ry + coord_t'(cmd_q.rect_height) - coord_t'(1);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i) begin
      cmd_q <= cmd_i;
      lx1_q <= coord_t'(cmd_i.x_start);
      ly1_q <= coord_t'(cmd_i.y_start);
      lx2_q <= coord_t'(cmd_i.x_end);
      ly2_q <= coord_t'(cmd_i.y_end);
      px_q <= '0;
      py_q <= coord_t'(cmd_i.radius);
      cd_q <= coord_t'(3) - (coord_t'(cmd_i.radius) <<< 1);
      oct_q <= '0;
      edge_q <= 2'd3;
    end
    if (state_q == StRectNext) begin
      edge_q <= edge_q + 2'd1;
      unique case (edge_q + 2'd1)
        2'd0: begin lx1_q <= rx; ly1_q <= ry; lx2_q <= rxr; ly2_q <= ry; end
        2'd1: begin lx1_q <= rx; ly1_q <= ryb; lx2_q <= rxr; ly2_q <= ryb; end
        2'd2: begin lx1_q <= rx; ly1_q <= ry; lx2_q <= rx; ly2_q <= ryb; end
        default: begin lx1_q <= rxr; ly1_q <= ry; lx2_q <= rxr; ly2_q <= ryb; end
      endcase
    end
    if (state_q == StLineSetup) begin
      steep_q <= lsteep;
      x_q <= lsteep ? ly1_q : lx1_q;
      y_q <= lsteep ? lx1_q : ly1_q;
      xe_q <= lsteep ? ly2_q : lx2_q;
      tx_q <= lsteep ? (ly2_q > ly1_q) : (lx2_q > lx1_q);
      ty_q <= lsteep ? (lx2_q > lx1_q) : (ly2_q > ly1_q);
      inc1_q <= (lsteep ? ldx : ldy) <<< 1;
      inc2_q <= ((lsteep ? ldx : ldy) - (lsteep ? ldy : ldx)) <<< 1;
      d_q <= ((lsteep ? ldx : ldy) <<< 1) - (lsteep ? ldy : ldx);
      first_q <= 1'b1;
    end
    if (state_q == StLine) begin
      if (first_q) begin
        first_q <= 1'b0;
        y_q <= y_step;
        d_q <= d_step;
      end else begin
        x_q <= x_next;
        if (!line_last) begin
          y_q <= y_step;
          d_q <= d_step;
        end
      end
    end
    if (state_q == StCircPlot) begin
      oct_q <= oct_q + 3'd1;
      if (oct_q == 3'd7) begin
        px_q <= px_q + coord_t'(1);
        if (cd_q[CoordW-1]) begin
          cd_q <= cd_q + (px_q <<< 2) + coord_t'(6);
        end else begin
          cd_q <= cd_q + ((px_q - py_q) <<< 2) + coord_t'(10);
          py_q <= py_q - coord_t'(1);
        end
      end
    end
    if (state_q == StDrain && cmd_q.mode == ModeGet) begin
      pix_q <= on_scr(coord_t'(cmd_q.x_start), coord_t'(cmd_q.y_start))
               ? rd_data_q[cmd_q.y_start[2:0]] : 1'b0;
    end else if (state_q == StIdle) begin
      pix_q <= 1'b0;
    end
  end

  // Get reads through the point path, so route its address there.
  logic get_rd;
  assign get_rd = (state_q == StGet);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      sweep_q <= '0;
      rd_v_q <= 1'b0;
      wr_v_q <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fill_we) begin
        sweep_q <= sweep_q + AddrW'(1);
      end
      rd_v_q <= pt_v && !get_rd && !(state_q == StLine && first_q)
                && on_scr(pt_x, pt_y);
      wr_v_q <= rd_v_q;
      hold_v_q <= wr_v_q;
    end
  end
endmodule

[src/mono_framebuffer_draw_engine_unit.sv]
// Channel  | Direction | Handshake        | Payload
// command  | in        | valid_i/stall_o  | mode_i .. fill_byte_i
// result   | out       | valid_o/stall_i  | pixel_value_o, done_res_o
// A line is walked along its major axis, a rectangle as four such lines, a circle by
// plotting all eight octants at each step, and a fill by writing every store byte.
// After reset a clearing pass zeroes the whole store before the first command starts.
// Up to two command words queue while the back end is busy or the result is stalled.
// Top level of the frame store drawing engine; depends on mfde_pkg, mfde_front, mfde_back.
`timescale 1ns / 1ps
module mono_framebuffer_draw_engine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [2:0] mode_i,
  input  logic [6:0] x_start_i,
  input  logic [5:0] y_start_i,
  input  logic [6:0] x_end_i,
  input  logic [5:0] y_end_i,
  input  logic [6:0] radius_i,
  input  logic [7:0] rect_width_i,
  input  logic [6:0] rect_height_i,
  input  logic       color_i,
  input  logic [7:0] fill_byte_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic       pixel_value_o,
  output logic       done_res_o
);
  import mfde_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  assign in_cmd = '{mode: mode_i, x_start: x_start_i, y_start: y_start_i,
                    x_end: x_end_i, y_end: y_end_i, radius: radius_i,
                    rect_width: rect_width_i, rect_height: rect_height_i,
                    color: color_i, fill_byte: fill_byte_i};

  mfde_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .cmd_i(in_cmd), .cmd_valid_o(q_valid), .cmd_pop_i(q_pop), .cmd_o(q_cmd)
  );

  mfde_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_valid_i(q_valid), .cmd_pop_o(q_pop),
    .cmd_i(q_cmd), .valid_o(valid_o), .stall_i(stall_i),
    .pixel_value_o(pixel_value_o)
  );

  assign done_res_o = 1'b1;
endmodule

[src/mfde_checker.sv]
// Port-level checks for the drawing engine, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfde_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_o,
  input logic stall_i,
  input logic pixel_value_o,
  input logic done_res_o
);
  `ASSERT_CLK(a_done_one, clk_i, rst_ni, valid_o |-> done_res_o, "done_res not set")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(pixel_value_o), "stalled word changed")
  `ASSERT_CLK(a_one_word, clk_i, rst_ni, valid_o && !stall_i |=> !valid_o, "result repeated")
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !valid_o, "result during reset")
endmodule

bind mono_framebuffer_draw_engine_unit mfde_port_checker u_mfde_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_o(valid_o), .stall_i(stall_i),
  .pixel_value_o(pixel_value_o), .done_res_o(done_res_o)
);
